// ----- design/ntrc_pkg.sv -----
package ntrc_pkg;

    // parser state, one per character of the number text
    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_ZERO  = 3'd1,
        MODE_HEX_X = 3'd2,
        MODE_HEX   = 3'd3,
        MODE_DEC   = 3'd4,
        MODE_OCT   = 3'd5,
        MODE_BIN   = 3'd6,
        MODE_BAD   = 3'd7
    } t_parse_mode;

    // formatter state
    typedef enum logic [1:0] {
        EMIT_IDLE  = 2'd0,
        EMIT_PFX0  = 2'd1,
        EMIT_PFX1  = 2'd2,
        EMIT_DIGIT = 2'd3
    } t_emit_state;

    typedef logic [1:0] t_base;

    localparam t_base BASE_HEX = 2'd0;
    localparam t_base BASE_OCT = 2'd1;
    localparam t_base BASE_BIN = 2'd2;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_O    = 8'h6f;
    localparam logic [7:0] CH_B    = 8'h62;

    localparam logic [8:0] OFS_DIGIT = 9'd48;
    localparam logic [8:0] OFS_ALPHA = 9'd55;

    localparam int unsigned VALUE_BITS = 32;

endpackage

// ----- design/ntrc_front.sv -----
module ntrc_front #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_char,
    input  logic                 i_final,
    input  logic                 i_q_ready,
    output logic                 o_push,
    output logic [WORD_BITS:0]   o_push_data
);
    import ntrc_pkg::*;

    t_parse_mode            r_mode, n_mode, p_mode;
    logic [WORD_BITS-1:0]   r_acc, n_acc, p_acc;
    logic                   accept;
    logic [8:0]             plain9, alpha9;
    logic [WORD_BITS+8:0]   plain_ext, alpha_ext;
    logic [WORD_BITS-1:0]   dig_plain, dig_hex;
    logic [WORD_BITS-1:0]   acc_x2, acc_x8, acc_x10, acc_x16;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    // digit values wrap modulo the word: sign-extend the 9-bit difference
    assign plain9    = {1'b0, i_char} - OFS_DIGIT;
    assign alpha9    = {1'b0, i_char} - OFS_ALPHA;
    assign plain_ext = {{WORD_BITS{plain9[8]}}, plain9};
    assign alpha_ext = {{WORD_BITS{alpha9[8]}}, alpha9};
    assign dig_plain = plain_ext[WORD_BITS-1:0];
    assign dig_hex   = (i_char >= CH_ZERO && i_char <= CH_NINE) ? dig_plain
                                                                : alpha_ext[WORD_BITS-1:0];

    assign acc_x2  = r_acc << 1;
    assign acc_x8  = r_acc << 3;
    assign acc_x10 = acc_x8 + acc_x2;
    assign acc_x16 = r_acc << 4;

    // parse of the current character
    always_comb begin
        p_mode = r_mode;
        p_acc  = r_acc;
        unique case (r_mode)
            MODE_START: begin
                p_acc = '0;
                if (i_char == CH_ZERO) begin
                    p_mode = MODE_ZERO;
                end else if (i_char >= CH_ONE && i_char <= CH_NINE) begin
                    p_mode = MODE_DEC;
                    p_acc  = dig_plain;
                end else if (i_char == CH_O) begin
                    p_mode = MODE_OCT;
                end else if (i_char == CH_B) begin
                    p_mode = MODE_BIN;
                end else begin
                    p_mode = MODE_BAD;
                end
            end
            MODE_ZERO: begin
                if (i_char == CH_X) begin
                    p_mode = MODE_HEX;
                end else begin
                    p_mode = MODE_DEC;
                    p_acc  = acc_x10 + dig_plain;
                end
            end
            MODE_HEX_X, MODE_HEX: begin
                p_mode = MODE_HEX;
                p_acc  = acc_x16 + dig_hex;
            end
            MODE_DEC: p_acc = acc_x10 + dig_plain;
            MODE_OCT: p_acc = acc_x8 + dig_plain;
            MODE_BIN: p_acc = acc_x2 + dig_plain;
            MODE_BAD: p_acc = '0;
            default:  p_acc = '0;
        endcase
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        if (accept) begin
            if (i_final) begin
                n_mode = MODE_START;
                n_acc  = '0;
            end else begin
                n_mode = p_mode;
                n_acc  = p_acc;
            end
        end
    end

    // finished number goes to the queue
    always_comb begin
        o_push      = accept && i_final;
        o_push_data = {(p_mode == MODE_BAD), p_acc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_acc  <= '0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

endmodule

// ----- design/ntrc_queue.sv -----
module ntrc_queue #(
    parameter int WIDTH = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push, do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- design/ntrc_back.sv -----
module ntrc_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ntrc_pkg::t_base           i_base,
    input  logic                      i_q_valid,
    input  logic [WORD_BITS:0]        i_q_data,
    output logic                      o_q_pop,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [7:0]                o_char,
    output logic [31:0]               o_value,
    output logic                      o_bad,
    output logic                      o_last
);
    import ntrc_pkg::*;

    localparam int SW     = WORD_BITS + 3;
    localparam int ND_HEX = (WORD_BITS + 3) / 4;
    localparam int ND_OCT = (WORD_BITS + 2) / 3;
    localparam int ND_BIN = WORD_BITS;
    localparam int SH_HEX = SW - ND_HEX * 4;
    localparam int SH_OCT = SW - ND_OCT * 3;
    localparam int SH_BIN = SW - ND_BIN;
    localparam int CW     = $clog2(WORD_BITS + 1);

    t_emit_state          r_state, n_state;
    t_base                r_base;
    logic [SW-1:0]        r_sh;
    logic [CW-1:0]        r_left;
    logic                 r_seen;
    logic [31:0]          r_val;
    logic                 r_bad;

    logic                 r_m_tvalid;
    logic [7:0]           r_char;
    logic                 r_last;

    logic                 can_load;
    logic                 emit;
    logic [7:0]           emit_char;
    logic                 emit_last;
    logic                 digit_step;
    logic [3:0]           digit;
    logic [SW-1:0]        load_ext;
    logic [WORD_BITS+31:0] val_ext;
    logic                 last_digit;

    assign can_load   = !r_m_tvalid || i_m_tready;
    assign last_digit = (r_left == CW'(1));
    assign load_ext   = {3'b000, i_q_data[WORD_BITS-1:0]};
    assign val_ext    = {32'd0, i_q_data[WORD_BITS-1:0]};

    // top digit of the aligned shift register
    always_comb begin
        unique case (r_base)
            BASE_OCT: digit = {1'b0, r_sh[SW-1 -: 3]};
            BASE_BIN: digit = {3'b000, r_sh[SW-1]};
            default:  digit = r_sh[SW-1 -: 4];
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EMIT_IDLE: begin
                if (i_q_valid && can_load) begin
                    n_state = EMIT_PFX0;
                end
            end
            EMIT_PFX0: begin
                if (can_load) begin
                    n_state = (r_base == BASE_OCT) ? EMIT_DIGIT : EMIT_PFX1;
                end
            end
            EMIT_PFX1: begin
                if (can_load) begin
                    n_state = EMIT_DIGIT;
                end
            end
            EMIT_DIGIT: begin
                if (can_load && last_digit) begin
                    n_state = EMIT_IDLE;
                end
            end
            default: n_state = EMIT_IDLE;
        endcase
    end

    // outputs of the formatter
    always_comb begin
        o_q_pop    = 1'b0;
        emit       = 1'b0;
        emit_char  = CH_ZERO;
        emit_last  = 1'b0;
        digit_step = 1'b0;
        unique case (r_state)
            EMIT_IDLE: begin
                // value and flag stay put until the last transfer of the run has left
                o_q_pop = i_q_valid && can_load;
            end
            EMIT_PFX0: begin
                emit = can_load;
            end
            EMIT_PFX1: begin
                emit      = can_load;
                emit_char = (r_base == BASE_BIN) ? CH_B : CH_X;
            end
            EMIT_DIGIT: begin
                digit_step = can_load;
                // leading zeros are skipped, the units digit always shows
                emit       = can_load && (r_seen || digit != 4'd0 || last_digit);
                emit_last  = last_digit;
                emit_char  = (digit > 4'd9) ? (8'(digit) + 8'(OFS_ALPHA))
                                            : (8'(digit) + 8'(OFS_DIGIT));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= EMIT_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (can_load) begin
                r_m_tvalid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_base <= i_base;
            r_val  <= val_ext[31:0];
            r_bad  <= i_q_data[WORD_BITS];
            r_seen <= 1'b0;
            unique case (i_base)
                BASE_OCT: begin
                    r_sh   <= load_ext << SH_OCT;
                    r_left <= CW'(ND_OCT);
                end
                BASE_BIN: begin
                    r_sh   <= load_ext << SH_BIN;
                    r_left <= CW'(ND_BIN);
                end
                default: begin
                    r_sh   <= load_ext << SH_HEX;
                    r_left <= CW'(ND_HEX);
                end
            endcase
        end else if (digit_step) begin
            r_left <= r_left - CW'(1);
            if (digit != 4'd0) begin
                r_seen <= 1'b1;
            end
            unique case (r_base)
                BASE_OCT: r_sh <= r_sh << 3;
                BASE_BIN: r_sh <= r_sh << 1;
                default:  r_sh <= r_sh << 4;
            endcase
        end
        if (emit) begin
            r_char <= emit_char;
            r_last <= emit_last;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_char     = r_char;
    assign o_value    = r_val;
    assign o_bad      = r_bad;
    assign o_last     = r_last;

endmodule

// ----- design/number_text_radix_converter.sv -----
// one character accepted per cycle unless the queue is full; the queue holds two finished numbers
// a finished number is written to the queue, popped by the formatter in its idle state, and its
// first character registered from the first prefix state; output text then gives one prefix character
// (0x hex, 0 octal, 0b binary) or digit position per cycle unless m_tready holds it, skipped leading
// zeros included: 8 hex, 11 octal, 32 binary digit positions at 32-bit words
// reset is synchronous, active low: parser at start of text, queue empty, base hex
module number_text_radix_converter #(
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // char_out [7:0], value [39:8]
    output logic        m_tuser,   // bad_prefix
    output logic        m_tlast
);
    import ntrc_pkg::*;

    t_base              r_output_base;
    logic               q_ready, q_valid, q_pop, push;
    logic [WORD_BITS:0] push_data, q_data;
    logic [7:0]         char_out;
    logic [31:0]        value_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_base <= BASE_HEX;
        end else if (i_cfg_we) begin
            r_output_base <= i_cfg_wdata;
        end
    end

    ntrc_front #(.WORD_BITS(WORD_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_char      (s_tdata),
        .i_final     (s_tlast),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_push_data (push_data)
    );

    ntrc_queue #(.WIDTH(WORD_BITS + 1)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    ntrc_back #(.WORD_BITS(WORD_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_base     (r_output_base),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_q_pop    (q_pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_char     (char_out),
        .o_value    (value_out),
        .o_bad      (m_tuser),
        .o_last     (m_tlast)
    );

    assign m_tdata = {value_out, char_out};

endmodule
